// File: sv/ncc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared types and constants of the nearest-centroid classifier: request
// actions, register indexes, the datapath tag and the sequencer states.
// ----------------------------------------------------------------------------
package ncc_pkg;

	// Coordinate fields on the request port and their width
	localparam int COORDS  = 8;
	localparam int COORD_W = 16;

	// Squared difference of one coordinate, and the sum over all lanes
	localparam int SQ_W   = 32;
	localparam int PAIR_W = SQ_W + 1;
	localparam int DIST_W = SQ_W + 3;

	localparam int LABEL_W = 4;
	localparam int CLU_W   = 5;
	localparam int DIM_W   = 4;

	// Request actions; the fourth code is ignored
	localparam logic [1:0] ACT_LOAD     = 2'd0;
	localparam logic [1:0] ACT_CLASSIFY = 2'd1;
	localparam logic [1:0] ACT_CLEAR    = 2'd2;

	// Configuration register indexes
	localparam logic REG_CLUSTERS = 1'b0;
	localparam logic REG_DIMS     = 1'b1;

	// Reset values of the configuration registers
	localparam logic [CLU_W-1:0] CLUSTERS_RST = 5'd16;
	localparam logic [DIM_W-1:0] DIMS_RST     = 4'd8;

	typedef logic [COORDS-1:0][COORD_W-1:0] coord_vec_t;

	// Tag that travels alongside one centroid through the distance pipeline
	typedef struct packed {
		logic               vld;
		logic               first;
		logic               last;
		logic [LABEL_W-1:0] label;
	} ncc_tag_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FIN
	} ncc_state_t;

endpackage

// File: sv/ncc_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_store
// Centroid memory: one row per centroid holding all of its coordinates.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ncc_store #(
	parameter int MAX_CLUSTERS = 16,
	parameter int MAX_DIMS     = 8
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [$clog2(MAX_CLUSTERS)-1:0]      waddr,
	input  logic [MAX_DIMS*ncc_pkg::COORD_W-1:0] wdata,
	input  logic                                 re,
	input  logic [$clog2(MAX_CLUSTERS)-1:0]      raddr,
	output logic [MAX_DIMS*ncc_pkg::COORD_W-1:0] rdata
);

	localparam int ROW_W = MAX_DIMS * ncc_pkg::COORD_W;

	logic [ROW_W-1:0] mem [MAX_CLUSTERS];
	logic [ROW_W-1:0] rdata_q;

	// Write one centroid row
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read one centroid row; the read data is registered and follows in the next cycle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/ncc_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_dist
// Squared Euclidean distance pipeline: one lane per coordinate squares the
// difference, then a registered adder tree sums the lanes in use.
// ----------------------------------------------------------------------------
module ncc_dist #(
	parameter int MAX_DIMS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pt_load,
	input  ncc_pkg::coord_vec_t                  coords,
	input  logic [ncc_pkg::DIM_W-1:0]            dims,
	input  logic [MAX_DIMS*ncc_pkg::COORD_W-1:0] row_s1,
	input  ncc_pkg::ncc_tag_t                    tag_s1,
	output logic [ncc_pkg::DIST_W-1:0]           dist_s4,
	output ncc_pkg::ncc_tag_t                    tag_s4
);

	localparam int CW = ncc_pkg::COORD_W;

	ncc_pkg::coord_vec_t pt_q;

	logic [ncc_pkg::COORDS-1:0][ncc_pkg::SQ_W-1:0]       sq_s2;
	logic [ncc_pkg::COORDS/2-1:0][ncc_pkg::PAIR_W-1:0]   pair_s3;
	logic [ncc_pkg::DIST_W-1:0]                          dist_q_s4;
	ncc_pkg::ncc_tag_t                                   tag_s2;
	ncc_pkg::ncc_tag_t                                   tag_s3;
	ncc_pkg::ncc_tag_t                                   tag_q_s4;

	// Hold the point of the current classify request
	always_ff @(posedge clk) begin
		if (pt_load) begin
			pt_q <= coords;
		end
	end

	// Square the coordinate difference in each lane; unused lanes give zero
	for (genvar d = 0; d < ncc_pkg::COORDS; d++) begin : g_lane
		if (d < MAX_DIMS) begin : g_used
			logic               lane_en;
			logic signed [CW:0] diff;
			logic signed [2*CW+1:0] prod;

			assign lane_en = (d == 0) || (dims > ncc_pkg::DIM_W'(d));
			assign diff = $signed({pt_q[d][CW-1], pt_q[d]})
				- $signed({row_s1[d*CW+CW-1], row_s1[d*CW +: CW]});
			assign prod = diff * diff;

			always_ff @(posedge clk) begin
				sq_s2[d] <= lane_en ? prod[ncc_pkg::SQ_W-1:0] : '0;
			end
		end else begin : g_unused
			assign sq_s2[d] = '0;
		end
	end

	// Add lane pairs
	always_ff @(posedge clk) begin
		for (int p = 0; p < ncc_pkg::COORDS / 2; p++) begin
			pair_s3[p] <= ncc_pkg::PAIR_W'(sq_s2[2*p]) + ncc_pkg::PAIR_W'(sq_s2[2*p+1]);
		end
	end

	// Add the pair sums into the full distance
	always_ff @(posedge clk) begin
		dist_q_s4 <= (ncc_pkg::DIST_W'(pair_s3[0]) + ncc_pkg::DIST_W'(pair_s3[1]))
			+ (ncc_pkg::DIST_W'(pair_s3[2]) + ncc_pkg::DIST_W'(pair_s3[3]));
	end

	// Advance the tag with its data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2   <= '0;
			tag_s3   <= '0;
			tag_q_s4 <= '0;
		end else begin
			tag_s2   <= tag_s1;
			tag_s3   <= tag_s2;
			tag_q_s4 <= tag_s3;
		end
	end

	assign dist_s4 = dist_q_s4;
	assign tag_s4  = tag_q_s4;

endmodule

// File: sv/ncc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_seq
// Request sequencer: configuration registers, model state, centroid read
// sweep, running minimum over the distance stream and the result register.
// ----------------------------------------------------------------------------
module ncc_seq #(
	parameter int MAX_CLUSTERS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [ncc_pkg::CLU_W-1:0]           cfg_data,
	// Request handshake
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          action,
	input  logic [3:0]                          centroid_slot,
	// Memory control
	output logic                                mem_we,
	output logic [$clog2(MAX_CLUSTERS)-1:0]     mem_waddr,
	output logic                                mem_re,
	output logic [$clog2(MAX_CLUSTERS)-1:0]     mem_raddr,
	// Distance pipeline
	output logic                                pt_load,
	output logic [ncc_pkg::DIM_W-1:0]           dims,
	output ncc_pkg::ncc_tag_t                   tag_s1,
	input  logic [ncc_pkg::DIST_W-1:0]          dist_s4,
	input  ncc_pkg::ncc_tag_t                   tag_s4,
	// Result handshake
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ncc_pkg::LABEL_W-1:0]         cluster_label,
	output logic                                model_empty
);

	localparam int AW = $clog2(MAX_CLUSTERS);

	ncc_pkg::ncc_state_t state_q, state_d;

	logic [AW-1:0]                   addr_q;
	logic [AW-1:0]                   last_idx;
	logic                            loaded_q;
	logic [ncc_pkg::CLU_W-1:0]       clusters_q;
	logic [ncc_pkg::DIM_W-1:0]       dims_q;
	ncc_pkg::ncc_tag_t               tag_q_s1;
	logic [ncc_pkg::DIST_W-1:0]      best_q;
	logic [ncc_pkg::LABEL_W-1:0]     best_lbl_q;
	logic [ncc_pkg::LABEL_W-1:0]     res_lbl_q;
	logic                            res_empty_q;
	logic                            out_vld_q;
	logic [ncc_pkg::LABEL_W-1:0]     out_lbl_q;
	logic                            out_empty_q;

	logic                            accept;
	logic                            issue;
	logic                            take_new;
	logic [ncc_pkg::LABEL_W-1:0]     win_lbl;
	logic                            slot_ok;

	assign accept  = in_valid && in_ready;
	assign slot_ok = 32'(centroid_slot) < MAX_CLUSTERS;

	// Last centroid index of the sweep, count clamped to 1..MAX_CLUSTERS
	always_comb begin
		priority if (clusters_q == '0) begin
			last_idx = '0;
		end else if (32'(clusters_q) > MAX_CLUSTERS) begin
			last_idx = AW'(MAX_CLUSTERS - 1);
		end else begin
			last_idx = AW'(clusters_q - 5'd1);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ncc_pkg::ST_IDLE: begin
				if (in_valid && action == ncc_pkg::ACT_CLASSIFY) begin
					state_d = loaded_q ? ncc_pkg::ST_RUN : ncc_pkg::ST_FIN;
				end
			end
			ncc_pkg::ST_RUN: begin
				if (addr_q == last_idx) begin
					state_d = ncc_pkg::ST_DRAIN;
				end
			end
			ncc_pkg::ST_DRAIN: begin
				if (tag_s4.vld && tag_s4.last) begin
					state_d = ncc_pkg::ST_FIN;
				end
			end
			ncc_pkg::ST_FIN: begin
				if (!out_vld_q || out_ready) begin
					state_d = ncc_pkg::ST_IDLE;
				end
			end
			default: state_d = ncc_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		take_new = 1'b0;
		unique case (state_q)
			ncc_pkg::ST_IDLE:  in_ready = 1'b1;
			ncc_pkg::ST_RUN:   issue    = 1'b1;
			ncc_pkg::ST_DRAIN: ;
			ncc_pkg::ST_FIN:   take_new = !out_vld_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ncc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clusters_q <= ncc_pkg::CLUSTERS_RST;
			dims_q     <= ncc_pkg::DIMS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ncc_pkg::REG_CLUSTERS: clusters_q <= cfg_data;
				ncc_pkg::REG_DIMS:     dims_q     <= cfg_data[ncc_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Track whether any centroid is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
		end else if (accept) begin
			if (action == ncc_pkg::ACT_LOAD && slot_ok) begin
				loaded_q <= 1'b1;
			end else if (action == ncc_pkg::ACT_CLEAR) begin
				loaded_q <= 1'b0;
			end
		end
	end

	// Sweep the read address over the centroids in use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (accept) begin
			addr_q <= '0;
		end else if (issue) begin
			addr_q <= addr_q + 1'b1;
		end
	end

	// Tag of the row read this cycle, aligned with the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q_s1 <= '0;
		end else begin
			tag_q_s1.vld   <= issue;
			tag_q_s1.first <= (addr_q == '0);
			tag_q_s1.last  <= (addr_q == last_idx);
			tag_q_s1.label <= ncc_pkg::LABEL_W'(addr_q);
		end
	end

	// Keep the running minimum; a tie keeps the earlier centroid
	assign win_lbl = (tag_s4.first || dist_s4 < best_q) ? tag_s4.label : best_lbl_q;

	always_ff @(posedge clk) begin
		if (tag_s4.vld && (tag_s4.first || dist_s4 < best_q)) begin
			best_q     <= dist_s4;
			best_lbl_q <= tag_s4.label;
		end
	end

	// Hold the finished result until the output register frees up
	always_ff @(posedge clk) begin
		if (accept && action == ncc_pkg::ACT_CLASSIFY && !loaded_q) begin
			res_lbl_q   <= '0;
			res_empty_q <= 1'b1;
		end else if (tag_s4.vld && tag_s4.last) begin
			res_lbl_q   <= win_lbl;
			res_empty_q <= 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (take_new) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_new) begin
			out_lbl_q   <= res_lbl_q;
			out_empty_q <= res_empty_q;
		end
	end

	assign mem_we        = accept && action == ncc_pkg::ACT_LOAD && slot_ok;
	assign mem_waddr     = AW'(centroid_slot);
	assign mem_re        = issue;
	assign mem_raddr     = addr_q;
	assign pt_load       = accept && action == ncc_pkg::ACT_CLASSIFY;
	assign dims          = dims_q;
	assign tag_s1        = tag_q_s1;
	assign out_valid     = out_vld_q;
	assign cluster_label = out_lbl_q;
	assign model_empty   = out_empty_q;

endmodule

// File: sv/nearest_centroid_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_centroid_classifier_top
// Nearest-centroid assignment of k-means over signed 16-bit coordinates.
// ----------------------------------------------------------------------------
// A load request writes one centroid row, and a clear request marks the
// model empty; neither gives a result. A classify request on a loaded model
// reads one stored centroid per cycle from the single read port of the
// centroid memory, sweeping K rows, where K is the clamped cluster count
// (up to MAX_CLUSTERS), and may then wait for the output register to drain;
// on an empty model it finishes with model_empty set and label zero. Each
// read row feeds one squaring lane per coordinate and a registered adder
// tree, and the lowest index wins a tie. Requests are taken only between
// classify sweeps; a finished result waits in the output register while
// further requests are accepted. The centroid memory is never cleared: a
// sweep compares every row below the cluster count, loaded or not.
// ----------------------------------------------------------------------------
module nearest_centroid_classifier_top #(
	parameter int MAX_CLUSTERS = 16,
	parameter int MAX_DIMS     = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [ncc_pkg::CLU_W-1:0]         cfg_data,
	// Request channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        action,
	input  logic [3:0]                        centroid_slot,
	input  logic signed [15:0]                coord_0,
	input  logic signed [15:0]                coord_1,
	input  logic signed [15:0]                coord_2,
	input  logic signed [15:0]                coord_3,
	input  logic signed [15:0]                coord_4,
	input  logic signed [15:0]                coord_5,
	input  logic signed [15:0]                coord_6,
	input  logic signed [15:0]                coord_7,
	// Result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ncc_pkg::LABEL_W-1:0]       cluster_label,
	output logic                              model_empty
);

	localparam int AW    = $clog2(MAX_CLUSTERS);
	localparam int ROW_W = MAX_DIMS * ncc_pkg::COORD_W;

	ncc_pkg::coord_vec_t             coords;
	logic [ncc_pkg::COORDS*ncc_pkg::COORD_W-1:0] coords_flat;
	logic                            mem_we;
	logic [AW-1:0]                   mem_waddr;
	logic                            mem_re;
	logic [AW-1:0]                   mem_raddr;
	logic [ROW_W-1:0]                row_s1;
	logic                            pt_load;
	logic [ncc_pkg::DIM_W-1:0]       dims;
	ncc_pkg::ncc_tag_t               tag_s1;
	ncc_pkg::ncc_tag_t               tag_s4;
	logic [ncc_pkg::DIST_W-1:0]      dist_s4;

	// Gather the coordinate fields, coordinate 0 in the low bits
	assign coords = {coord_7, coord_6, coord_5, coord_4,
		coord_3, coord_2, coord_1, coord_0};
	assign coords_flat = coords;

	ncc_seq #(
		.MAX_CLUSTERS (MAX_CLUSTERS)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.centroid_slot (centroid_slot),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_re        (mem_re),
		.mem_raddr     (mem_raddr),
		.pt_load       (pt_load),
		.dims          (dims),
		.tag_s1        (tag_s1),
		.dist_s4       (dist_s4),
		.tag_s4        (tag_s4),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cluster_label (cluster_label),
		.model_empty   (model_empty)
	);

	ncc_store #(
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.MAX_DIMS     (MAX_DIMS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (coords_flat[ROW_W-1:0]),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (row_s1)
	);

	ncc_dist #(
		.MAX_DIMS (MAX_DIMS)
	) u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.pt_load (pt_load),
		.coords  (coords),
		.dims    (dims),
		.row_s1  (row_s1),
		.tag_s1  (tag_s1),
		.dist_s4 (dist_s4),
		.tag_s4  (tag_s4)
	);

endmodule

// File: tb/nearest_centroid_classifier_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_centroid_classifier_top_tb
// Self-checking bench for the nearest-centroid classifier. A driver feeds
// requests from a backlog queue over the valid/ready request channel and a
// monitor checks every label on the result channel against an in-bench
// model of the centroid store. The run starts with a short directed
// sequence and then runs random phases under several cluster and dimension
// settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module nearest_centroid_classifier_top_tb;

	localparam int         N_SLOTS     = 16;
	localparam int         N_DIMS      = 8;
	localparam int         SETTLE_CYC  = 40;
	localparam logic [1:0] ACT_IGNORED = 2'd3;

	typedef struct packed {
		logic [1:0]          act;
		logic [3:0]          slot;
		ncc_pkg::coord_vec_t c;
	} ncc_req_t;

	typedef struct packed {
		logic [ncc_pkg::LABEL_W-1:0] label;
		logic                        empty;
	} ncc_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                        cfg_we = 1'b0;
	logic                        cfg_index = ncc_pkg::REG_CLUSTERS;
	logic [ncc_pkg::CLU_W-1:0]   cfg_data = '0;

	logic                        in_valid = 1'b0;
	logic                        in_ready;
	ncc_req_t                    cur_req = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [ncc_pkg::LABEL_W-1:0] cluster_label;
	logic                        model_empty;

	// Request backlog, expected labels and run state
	ncc_req_t req_backlog[$];
	ncc_res_t pending_labels[$];
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;
	int       mismatches = 0;

	// Shadow copy of the classifier state
	logic signed [ncc_pkg::COORD_W-1:0] centroid_mem [N_SLOTS][N_DIMS];
	bit                                 model_loaded;
	logic [ncc_pkg::CLU_W-1:0]          clusters_cfg;
	logic [ncc_pkg::DIM_W-1:0]          dims_cfg;

	nearest_centroid_classifier_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (cur_req.act),
		.centroid_slot(cur_req.slot),
		.coord_0      (cur_req.c[0]),
		.coord_1      (cur_req.c[1]),
		.coord_2      (cur_req.c[2]),
		.coord_3      (cur_req.c[3]),
		.coord_4      (cur_req.c[4]),
		.coord_5      (cur_req.c[5]),
		.coord_6      (cur_req.c[6]),
		.coord_7      (cur_req.c[7]),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cluster_label(cluster_label),
		.model_empty  (model_empty)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Update the shadow store and queue the label a classify should produce
	function automatic void predict_nearest(ncc_req_t r);
		longint best_dist;
		longint sq_sum;
		longint diff;
		int     k;
		int     nd;
		int     best;
		if (r.act == ncc_pkg::ACT_LOAD) begin
			for (int d = 0; d < N_DIMS; d++)
				centroid_mem[r.slot][d] = $signed(r.c[d]);
			model_loaded = 1'b1;
		end else if (r.act == ncc_pkg::ACT_CLEAR) begin
			model_loaded = 1'b0;
		end else if (r.act == ncc_pkg::ACT_CLASSIFY) begin
			if (!model_loaded) begin
				pending_labels.push_back('{label: '0, empty: 1'b1});
			end else begin
				k = (clusters_cfg == 0) ? 1 : (clusters_cfg > N_SLOTS) ? N_SLOTS : clusters_cfg;
				nd = (dims_cfg == 0) ? 1 : (dims_cfg > N_DIMS) ? N_DIMS : dims_cfg;
				best = 0;
				best_dist = -1;
				for (int s = 0; s < k; s++) begin
					sq_sum = 0;
					for (int d = 0; d < nd; d++) begin
						diff = longint'($signed(r.c[d])) - longint'(centroid_mem[s][d]);
						sq_sum += diff * diff;
					end
					// strict compare keeps the lowest index on a tie
					if (best_dist < 0 || sq_sum < best_dist) begin
						best_dist = sq_sum;
						best = s;
					end
				end
				pending_labels.push_back('{label: best[ncc_pkg::LABEL_W-1:0], empty: 1'b0});
			end
		end
	endfunction

	// Driver: hold a request until taken, then pull the next one or idle
	always @(posedge clk or negedge arst_n) begin : req_driver
		ncc_req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				predict_nearest(cur_req);
			if (!in_valid || in_ready) begin
				if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = req_backlog.pop_front();
					cur_req <= nxt;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic flag_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch: %s", $realtime, msg);
	endtask

	// Monitor: check each taken result against the oldest expected label
	always @(posedge clk or negedge arst_n) begin : res_monitor
		ncc_res_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_labels.size() == 0) begin
					flag_mismatch($sformatf("unexpected result label %0d model_empty %0b",
						cluster_label, model_empty));
				end else begin
					want = pending_labels.pop_front();
					if (cluster_label !== want.label)
						flag_mismatch($sformatf("cluster_label expected %0d got %0d",
							want.label, cluster_label));
					if (model_empty !== want.empty)
						flag_mismatch($sformatf("model_empty expected %0b got %0b",
							want.empty, model_empty));
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Wait until every request is taken and every label has come back
	task automatic wait_idle();
		@(negedge clk);
		while (req_backlog.size() != 0 || in_valid || pending_labels.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [ncc_pkg::CLU_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == ncc_pkg::REG_CLUSTERS)
			clusters_cfg = val;
		else
			dims_cfg = val[ncc_pkg::DIM_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_req(logic [1:0] act, logic [3:0] slot, ncc_pkg::coord_vec_t v);
		req_backlog.push_back('{act: act, slot: slot, c: v});
	endtask

	// Mostly extremes and small values near zero, so ties come up often
	function automatic logic [ncc_pkg::COORD_W-1:0] pick_coord();
		logic [ncc_pkg::COORD_W-1:0] v;
		case ($urandom_range(0, 7))
			0: v = 16'h8000;
			1: v = 16'h7FFF;
			2, 3, 4: v = 16'($urandom_range(0, 6)) - 16'd3;
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	// Queue random requests until count of them do real work, then drain
	task automatic run_items(int count);
		ncc_req_t r;
		int       done;
		int       pick;
		done = 0;
		while (done < count) begin
			pick = $urandom_range(0, 99);
			r.slot = 4'($urandom);
			for (int d = 0; d < N_DIMS; d++)
				r.c[d] = pick_coord();
			if (pick < 30)
				r.act = ncc_pkg::ACT_LOAD;
			else if (pick < 86)
				r.act = ncc_pkg::ACT_CLASSIFY;
			else if (pick < 96)
				r.act = ncc_pkg::ACT_CLEAR;
			else
				r.act = ACT_IGNORED;
			req_backlog.push_back(r);
			if (r.act != ACT_IGNORED)
				done++;
		end
		wait_idle();
	endtask

	// One random phase: new settings while idle, then two bursts of requests
	task automatic run_phase(logic [ncc_pkg::CLU_W-1:0] k, logic [ncc_pkg::DIM_W-1:0] nd,
			int snd_idle, int rcv_idle, int count);
		wait_idle();
		repeat (SETTLE_CYC) @(posedge clk);
		write_reg(ncc_pkg::REG_CLUSTERS, k);
		write_reg(ncc_pkg::REG_DIMS, {1'b0, nd});
		send_idle_pct = snd_idle;
		recv_idle_pct = rcv_idle;
		run_items(count / 2);
		run_items(count - count / 2);
	endtask

	initial begin : stimulus
		ncc_pkg::coord_vec_t v;
		model_loaded = 1'b0;
		clusters_cfg = ncc_pkg::CLUSTERS_RST;
		dims_cfg = ncc_pkg::DIMS_RST;
		for (int s = 0; s < N_SLOTS; s++)
			for (int d = 0; d < N_DIMS; d++)
				centroid_mem[s][d] = '0;
		send_idle_pct = 22;
		recv_idle_pct = 45;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty model, ignored action, load and clear, then fill slots 1 to 15
		push_req(ncc_pkg::ACT_CLASSIFY, 4'd0, '0);
		push_req(ACT_IGNORED, 4'hF, {8{16'h7FFF}});
		push_req(ncc_pkg::ACT_LOAD, 4'd0, {8{16'h8000}});
		push_req(ncc_pkg::ACT_CLEAR, 4'd0, '0);
		push_req(ncc_pkg::ACT_CLASSIFY, 4'd0, '0);
		push_req(ncc_pkg::ACT_LOAD, 4'd1, {8{16'h7FFF}});
		push_req(ncc_pkg::ACT_LOAD, 4'd2, '0);
		push_req(ncc_pkg::ACT_LOAD, 4'd3, '0);
		for (int s = 4; s < N_SLOTS; s++) begin
			for (int d = 0; d < N_DIMS; d++)
				v[d] = 16'($urandom);
			push_req(ncc_pkg::ACT_LOAD, 4'(s), v);
		end
		// Extreme points, a tie between two equal centroids, then clear
		push_req(ncc_pkg::ACT_CLASSIFY, 4'd0, {8{16'h7FFF}});
		push_req(ncc_pkg::ACT_CLASSIFY, 4'd0, {8{16'h8000}});
		push_req(ncc_pkg::ACT_CLASSIFY, 4'hF, '0);
		push_req(ncc_pkg::ACT_CLASSIFY, 4'd5, {4{16'h7FFF, 16'h8000}});
		push_req(ncc_pkg::ACT_CLEAR, 4'd0, '0);
		push_req(ncc_pkg::ACT_CLASSIFY, 4'd0, {8{16'h7FFF}});
		wait_idle();

		// Random phases over the register extremes and idling patterns
		run_phase(5'd16, 4'd8, 22, 45, 117);
		run_phase(5'd1, 4'd1, 22, 45, 117);
		run_phase(5'd0, 4'd0, 45, 22, 117);
		run_phase(5'd31, 4'd15, 45, 22, 117);
		run_phase(5'd7, 4'd3, 0, 0, 116);
		run_phase(5'd12, 4'd5, 0, 0, 116);

		wait_idle();
		repeat (SETTLE_CYC) @(posedge clk);
		if (mismatches == 0)
			$display("PASS nearest_centroid_classifier_top");
		else
			$display("FAIL nearest_centroid_classifier_top");
		$finish;
	end

	// Hard stop if the handshakes hang
	initial begin
		#5_000_000;
		$display("FAIL nearest_centroid_classifier_top");
		$finish;
	end

endmodule
